// ===== hw/rtl/dsdt_pkg.sv =====
// Shared types and constants for the dual-stage diffusion trial block.
// Used by dsdt_noise, the top level and the port checker.
package dsdt_pkg;

  localparam int LEVEL_W  = 32;   // accumulator width, Q16.16
  localparam int SMP_W    = 16;   // noise sample, Q4.12
  localparam int GAIN_W   = 32;   // noise gain, unsigned Q16.16
  localparam int PROD_W   = GAIN_W + SMP_W;
  localparam int FRAC_SH  = 12;   // Q20.28 -> Q16.16
  localparam int TERM_W   = PROD_W - FRAC_SH + 1;
  localparam int DRIFT_W  = 32;
  localparam int BOUND_W  = 31;
  localparam int TICK_W   = 32;
  localparam int SUM_W    = ((LEVEL_W > TERM_W) ? LEVEL_W : TERM_W) + 2;

  localparam logic [BOUND_W-1:0] BOUND_RST = BOUND_W'(65536);

  typedef enum logic [2:0] {
    CFG_RESPONSE_BOUND,
    CFG_SELECTION_BOUND,
    CFG_DRIFT_STAGE_ONE,
    CFG_DRIFT_AFTER_UPPER,
    CFG_DRIFT_AFTER_LOWER,
    CFG_DRIFT_SELECTION,
    CFG_NOISE_GAIN,
    CFG_NONDECISION_TICKS
  } cfg_idx_t;

  typedef enum logic [1:0] {
    PH_ONE,
    PH_UPPER,
    PH_LOWER
  } phase_t;

  // Sample split into sign and magnitude, held in the input register
  typedef struct packed {
    logic             neg;
    logic [SMP_W-1:0] mag;
  } smp_sm_t;

  function automatic logic signed [LEVEL_W-1:0] sat_level(
    input logic signed [SUM_W-1:0] v
  );
    logic signed [SUM_W-1:0] hi;
    logic signed [SUM_W-1:0] lo;
    hi = SUM_W'(signed'({1'b0, {(LEVEL_W-1){1'b1}}}));
    lo = -hi - SUM_W'(1);
    if (v > hi) begin
      sat_level = hi[LEVEL_W-1:0];
    end else if (v < lo) begin
      sat_level = lo[LEVEL_W-1:0];
    end else begin
      sat_level = v[LEVEL_W-1:0];
    end
  endfunction

endpackage

// ===== hw/rtl/dsdt_noise.sv =====
// Noise term stage: gain times sample magnitude, rounded half away from zero
// back to Q16.16, sign restored, registered. Depends on dsdt_pkg.
module dsdt_noise import dsdt_pkg::*; (
  input  logic                     clk,
  input  logic                     load,
  input  smp_sm_t                  smp,
  input  logic [GAIN_W-1:0]        gain,
  output logic signed [TERM_W-1:0] term_r
);

  logic [PROD_W-1:0]       prod;
  logic [PROD_W-1:0]       rnd;
  logic signed [TERM_W-1:0] term_nxt;

  always_comb begin
    prod     = PROD_W'(gain) * PROD_W'(smp.mag);
    rnd      = prod + PROD_W'(2048);
    term_nxt = signed'({1'b0, rnd[PROD_W-1:FRAC_SH]});
    if (smp.neg) begin
      term_nxt = -term_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      term_r <= term_nxt;
    end
  end

endmodule

// ===== hw/rtl/dual_stage_diffusion_trial.sv =====
// Dual-stage diffusion trial: one time tick per accepted noise pair, one item
// per clock cycle sustained while no result is held on out_stall. Items pass the
// input register, noise multiply and level update in turn; the level update and
// crossing test set the rate. While a result waits on out_stall, up to two further
// items are held inside; in_stall rises only when the next deciding item reaches
// the level update. Depends on dsdt_pkg.
module dual_stage_diffusion_trial import dsdt_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic signed [SMP_W-1:0]  in_noise_response,
  input  logic signed [SMP_W-1:0]  in_noise_selection,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic                     out_choice,
  output logic [TICK_W-1:0]        out_reaction_ticks,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [2:0]               cfg_index,
  input  logic [31:0]              cfg_data
);

  // configuration
  logic [BOUND_W-1:0]        resp_bound_r, sel_bound_r;
  logic signed [DRIFT_W-1:0] drift_one_r, drift_up_r, drift_lo_r, drift_sel_r;
  logic [GAIN_W-1:0]         gain_r;
  logic [TICK_W-1:0]         nd_ticks_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      resp_bound_r <= BOUND_RST;
      sel_bound_r  <= BOUND_RST;
      drift_one_r  <= '0;
      drift_up_r   <= '0;
      drift_lo_r   <= '0;
      drift_sel_r  <= '0;
      gain_r       <= '0;
      nd_ticks_r   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_RESPONSE_BOUND:    resp_bound_r <= cfg_data[BOUND_W-1:0];
        CFG_SELECTION_BOUND:   sel_bound_r  <= cfg_data[BOUND_W-1:0];
        CFG_DRIFT_STAGE_ONE:   drift_one_r  <= signed'(cfg_data);
        CFG_DRIFT_AFTER_UPPER: drift_up_r   <= signed'(cfg_data);
        CFG_DRIFT_AFTER_LOWER: drift_lo_r   <= signed'(cfg_data);
        CFG_DRIFT_SELECTION:   drift_sel_r  <= signed'(cfg_data);
        CFG_NOISE_GAIN:        gain_r       <= cfg_data;
        CFG_NONDECISION_TICKS: nd_ticks_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // pipeline control
  logic v1_r, v2_r, out_valid_r;
  logic adv1, adv2, fire3, decide;
  logic out_free;

  assign out_free = !out_valid_r || !out_stall;
  assign fire3    = v2_r && (out_free || !decide);
  assign adv2     = !v2_r || fire3;
  assign adv1     = !v1_r || adv2;
  assign in_stall = !adv1;

  // input register: sign and magnitude of both samples
  smp_sm_t resp_smp_r, sel_smp_r;

  always_ff @(posedge clk) begin
    if (adv1) begin
      resp_smp_r.neg <= in_noise_response[SMP_W-1];
      resp_smp_r.mag <= in_noise_response[SMP_W-1] ?
                        SMP_W'(-in_noise_response) : SMP_W'(in_noise_response);
      sel_smp_r.neg  <= in_noise_selection[SMP_W-1];
      sel_smp_r.mag  <= in_noise_selection[SMP_W-1] ?
                        SMP_W'(-in_noise_selection) : SMP_W'(in_noise_selection);
    end
  end

  // noise terms
  logic signed [TERM_W-1:0] resp_term_r, sel_term_r;
  logic                     term_load;

  assign term_load = adv2 && v1_r;

  dsdt_noise u_noise_resp (
    .clk    (clk),
    .load   (term_load),
    .smp    (resp_smp_r),
    .gain   (gain_r),
    .term_r (resp_term_r)
  );

  dsdt_noise u_noise_sel (
    .clk    (clk),
    .load   (term_load),
    .smp    (sel_smp_r),
    .gain   (gain_r),
    .term_r (sel_term_r)
  );

  // trial state
  logic signed [LEVEL_W-1:0] resp_lvl_r, resp_lvl_nxt;
  logic signed [LEVEL_W-1:0] sel_lvl_r, sel_lvl_nxt;
  phase_t                    phase_r, phase_nxt;
  logic [TICK_W-1:0]         tick_r, tick_inc;
  logic signed [DRIFT_W-1:0] resp_drift;
  logic                      stage_one;
  logic signed [SUM_W-1:0]   resp_sum, sel_sum, a_s, c_s, resp_ext, sel_ext;
  logic                      resp_lo, resp_hi;
  logic [TICK_W:0]           rt_sum;
  logic [TICK_W-1:0]         rt_sat;

  always_comb begin
    case (phase_r) inside
      PH_UPPER, PH_LOWER: stage_one = 1'b0;
      default:            stage_one = 1'b1;
    endcase
    if (stage_one) begin
      resp_drift = drift_one_r;
    end else if (phase_r == PH_UPPER) begin
      resp_drift = drift_up_r;
    end else begin
      resp_drift = drift_lo_r;
    end

    a_s = signed'(SUM_W'(resp_bound_r));
    c_s = signed'(SUM_W'(sel_bound_r));

    resp_sum = SUM_W'(resp_lvl_r) + SUM_W'(resp_drift) + SUM_W'(resp_term_r);
    sel_sum  = SUM_W'(sel_lvl_r) + SUM_W'(drift_sel_r) + SUM_W'(sel_term_r);
    resp_lvl_nxt = sat_level(resp_sum);
    sel_lvl_nxt  = stage_one ? sat_level(sel_sum) : sel_lvl_r;
    resp_ext = SUM_W'(resp_lvl_nxt);
    sel_ext  = SUM_W'(sel_lvl_nxt);

    // lower test first: zero level on a zero bound picks the lower side
    resp_lo = resp_ext <= -a_s;
    resp_hi = resp_ext >= a_s;
    decide  = resp_lo || resp_hi;

    phase_nxt = phase_r;
    if (stage_one && !decide) begin
      if (sel_ext >= c_s) begin
        phase_nxt = PH_UPPER;
      end else if (sel_ext <= -c_s) begin
        phase_nxt = PH_LOWER;
      end else begin
        phase_nxt = PH_ONE;
      end
    end

    tick_inc = (tick_r == '1) ? tick_r : tick_r + TICK_W'(1);
    rt_sum   = {1'b0, tick_inc} + {1'b0, nd_ticks_r};
    rt_sat   = rt_sum[TICK_W] ? '1 : rt_sum[TICK_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r       <= 1'b0;
      v2_r       <= 1'b0;
      resp_lvl_r <= '0;
      sel_lvl_r  <= '0;
      phase_r    <= PH_ONE;
      tick_r     <= '0;
    end else begin
      if (adv1) begin
        v1_r <= in_valid;
      end
      if (adv2) begin
        v2_r <= v1_r;
      end
      if (fire3) begin
        if (decide) begin
          resp_lvl_r <= '0;
          sel_lvl_r  <= '0;
          phase_r    <= PH_ONE;
          tick_r     <= '0;
        end else begin
          resp_lvl_r <= resp_lvl_nxt;
          sel_lvl_r  <= sel_lvl_nxt;
          phase_r    <= phase_nxt;
          tick_r     <= tick_inc;
        end
      end
    end
  end

  // result register
  logic              choice_r;
  logic [TICK_W-1:0] rt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire3 && decide) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire3 && decide) begin
      choice_r <= !resp_lo;
      rt_r     <= rt_sat;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_choice         = choice_r;
  assign out_reaction_ticks = rt_r;

endmodule

// ===== hw/rtl/dsdt_port_check.sv =====
// Port-level checker for dual_stage_diffusion_trial, bound to the top level.
// Depends on dsdt_pkg.
module dsdt_port_check import dsdt_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_stall,
  input logic              out_choice,
  input logic [TICK_W-1:0] out_reaction_ticks,
  input logic              cfg_ready
);

  // a result waiting on the receiver keeps its fields
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_choice)
      && $stable(out_reaction_ticks))
    else $error("stalled result changed");

  // reset leaves no result pending
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // every result counts at least one tick
  a_rt_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_reaction_ticks != '0)
    else $error("zero reaction time");

  // config writes are never refused
  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_ready)
    else $error("config port not ready");

endmodule

bind dual_stage_diffusion_trial dsdt_port_check u_port_check (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .out_choice         (out_choice),
  .out_reaction_ticks (out_reaction_ticks),
  .cfg_ready          (cfg_ready)
);

// ===== test/testbench.sv =====
// Self-checking bench for dual_stage_diffusion_trial: directed rows, then
// eight randomly configured phases of noise pairs under varied handshake idling.
// Depends on dsdt_pkg and the dual_stage_diffusion_trial top level.
module testbench;
  import dsdt_pkg::*;

  localparam int SETTLE          = 6;    // covers the result pipeline
  localparam int HANG_LIMIT      = 2000;
  localparam int PHASES          = 8;
  localparam int PAIRS_PER_PHASE = 200;

  typedef enum logic [1:0] {CHK_PRED, CHK_NONE, CHK_HIT} row_check_t;
  typedef enum logic {ROW_REG, ROW_PAIR} row_kind_t;

  typedef struct {
    row_kind_t               kind;
    cfg_idx_t                idx;
    logic [31:0]             data;
    logic signed [SMP_W-1:0] nr;
    logic signed [SMP_W-1:0] ns;
    row_check_t              chk;
    logic                    ch;
    logic [TICK_W-1:0]       rt;
  } stim_row_t;

  typedef struct {
    logic              choice;
    logic [TICK_W-1:0] ticks;
  } decision_t;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic signed [SMP_W-1:0] in_noise_response = '0;
  logic signed [SMP_W-1:0] in_noise_selection = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic                    out_choice;
  logic [TICK_W-1:0]       out_reaction_ticks;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  cfg_idx_t                cfg_index = CFG_RESPONSE_BOUND;
  logic [31:0]             cfg_data = '0;

  dual_stage_diffusion_trial DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_noise_response  (in_noise_response),
    .in_noise_selection (in_noise_selection),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_choice         (out_choice),
    .out_reaction_ticks (out_reaction_ticks),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Shadow registers
  logic [BOUND_W-1:0]        resp_bound = BOUND_RST;
  logic [BOUND_W-1:0]        sel_bound = BOUND_RST;
  logic signed [DRIFT_W-1:0] drift_one = '0;
  logic signed [DRIFT_W-1:0] drift_up = '0;
  logic signed [DRIFT_W-1:0] drift_low = '0;
  logic signed [DRIFT_W-1:0] drift_sel = '0;
  logic [GAIN_W-1:0]         gain_r = '0;
  logic [TICK_W-1:0]         nondec = '0;

  // Trial state of the predictor
  longint                    resp_lvl = 0;
  longint                    sel_lvl = 0;
  phase_t                    trial_phase = PH_ONE;
  logic [TICK_W-1:0]         tick_cnt = '0;

  decision_t pending_decisions[$];
  int        send_gap_pct = 0;
  int        stall_pct = 0;
  bit        busy = 1'b0;
  int        pairs_sent = 0;
  int        decisions_seen = 0;
  int        reg_writes = 0;
  int        mismatches = 0;
  int        quiet_cycles = 0;

  // gain * |sample| rescaled Q20.28 -> Q16.16, rounded half away from zero
  function automatic longint scaled_noise(logic signed [SMP_W-1:0] s);
    longint mag;
    longint p;
    mag = (s < 0) ? -longint'(s) : longint'(s);
    p = (longint'(gain_r) * mag + 2048) >>> 12;
    return (s < 0) ? -p : p;
  endfunction

  function automatic longint step_level(longint lvl, longint drift,
                                        logic signed [SMP_W-1:0] s);
    longint hi;
    longint lo;
    longint v;
    hi = (longint'(1) << (LEVEL_W - 1)) - 1;
    lo = -hi - 1;
    v = lvl + drift + scaled_noise(s);
    if (v > hi) v = hi;
    if (v < lo) v = lo;
    return v;
  endfunction

  // One tick of the trial; returns 1 when the tick decides it
  function automatic bit advance_trial(input logic signed [SMP_W-1:0] nr,
                                       input logic signed [SMP_W-1:0] ns,
                                       output logic ch, output logic [TICK_W-1:0] rt);
    longint a;
    longint c;
    longint sum;
    a = longint'(resp_bound);
    c = longint'(sel_bound);
    ch = 1'b0;
    rt = '0;
    if (tick_cnt != '1) tick_cnt = tick_cnt + 1'b1;
    if (trial_phase == PH_UPPER || trial_phase == PH_LOWER) begin
      resp_lvl = step_level(resp_lvl, (trial_phase == PH_UPPER) ? drift_up : drift_low, nr);
    end else begin
      sel_lvl = step_level(sel_lvl, drift_sel, ns);
      resp_lvl = step_level(resp_lvl, drift_one, nr);
      if (resp_lvl > -a && resp_lvl < a) begin
        // upper selection test first: zero level on a zero bound goes upper
        if (sel_lvl >= c) trial_phase = PH_UPPER;
        else if (sel_lvl <= -c) trial_phase = PH_LOWER;
        return 1'b0;
      end
    end
    // lower response test first: zero level on a zero bound gives choice 0
    if (resp_lvl <= -a) ch = 1'b0;
    else if (resp_lvl >= a) ch = 1'b1;
    else return 1'b0;
    sum = longint'(tick_cnt) + longint'(nondec);
    rt = (sum > 64'hFFFF_FFFF) ? '1 : sum[TICK_W-1:0];
    resp_lvl = 0;
    sel_lvl = 0;
    trial_phase = PH_ONE;
    tick_cnt = '0;
    return 1'b1;
  endfunction

  function automatic stim_row_t reg_row(cfg_idx_t idx, logic [31:0] data);
    return '{ROW_REG, idx, data, '0, '0, CHK_NONE, 1'b0, '0};
  endfunction

  function automatic stim_row_t pair_row(logic signed [SMP_W-1:0] nr,
                                         logic signed [SMP_W-1:0] ns, row_check_t chk,
                                         logic ch, logic [TICK_W-1:0] rt);
    return '{ROW_PAIR, CFG_RESPONSE_BOUND, '0, nr, ns, chk, ch, rt};
  endfunction

  // Mostly near-unit samples, a quarter over the whole range
  function automatic logic signed [SMP_W-1:0] draw_sample();
    if ($urandom_range(3) != 0) return SMP_W'($urandom_range(8191)) - SMP_W'(4096);
    return SMP_W'($urandom_range(65535));
  endfunction

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_decisions.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    busy = 1'b0;
  endtask

  // Leaves cfg_valid high so back-to-back writes need no idle gap between them
  task automatic write_reg(cfg_idx_t idx, logic [31:0] data);
    if (busy) drain();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    reg_writes++;
    case (idx)
      CFG_RESPONSE_BOUND:    resp_bound = data[BOUND_W-1:0];
      CFG_SELECTION_BOUND:   sel_bound  = data[BOUND_W-1:0];
      CFG_DRIFT_STAGE_ONE:   drift_one  = data;
      CFG_DRIFT_AFTER_UPPER: drift_up   = data;
      CFG_DRIFT_AFTER_LOWER: drift_low  = data;
      CFG_DRIFT_SELECTION:   drift_sel  = data;
      CFG_NOISE_GAIN:        gain_r     = data;
      CFG_NONDECISION_TICKS: nondec     = data;
      default: ;
    endcase
  endtask

  task automatic send_pair(stim_row_t row);
    decision_t d;
    bit        hit;
    cfg_valid <= 1'b0;
    while (send_gap_pct != 0 && $urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid           <= 1'b1;
    in_noise_response  <= row.nr;
    in_noise_selection <= row.ns;
    do @(posedge clk); while (in_stall);
    busy = 1'b1;
    pairs_sent++;
    hit = advance_trial(row.nr, row.ns, d.choice, d.ticks);
    if (row.chk == CHK_HIT) begin
      d.choice = row.ch;
      d.ticks  = row.rt;
    end
    if (row.chk == CHK_HIT || (row.chk == CHK_PRED && hit))
      pending_decisions = {pending_decisions, d};
  endtask

  task automatic configure_phase(int p);
    logic [31:0] v[8];
    v[CFG_RESPONSE_BOUND]    = $urandom_range(32'h40000, 32'h4000);
    v[CFG_SELECTION_BOUND]   = $urandom_range(32'h40000, 0);
    v[CFG_DRIFT_STAGE_ONE]   = $urandom_range(32'h4000) - 32'h2000;
    v[CFG_DRIFT_AFTER_UPPER] = $urandom_range(32'h4000) - 32'h2000;
    v[CFG_DRIFT_AFTER_LOWER] = $urandom_range(32'h4000) - 32'h2000;
    v[CFG_DRIFT_SELECTION]   = $urandom_range(32'h4000) - 32'h2000;
    v[CFG_NOISE_GAIN]        = $urandom_range(32'h20000, 32'h2000);
    v[CFG_NONDECISION_TICKS] = $urandom_range(300);
    case (p)
      4: begin
        // zero or tiny bounds: nearly every tick decides
        v[CFG_RESPONSE_BOUND]  = $urandom_range(1);
        v[CFG_SELECTION_BOUND] = $urandom_range(1);
      end
      5: begin
        // widest bounds, full-scale drift and gain: levels saturate
        v[CFG_RESPONSE_BOUND]    = 32'h7FFF_FFFF;
        v[CFG_SELECTION_BOUND]   = 32'h7FFF_FFFF;
        v[CFG_DRIFT_STAGE_ONE]   = $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
        v[CFG_DRIFT_AFTER_UPPER] = 32'h7FFF_FFFF;
        v[CFG_DRIFT_AFTER_LOWER] = 32'h8000_0000;
        v[CFG_DRIFT_SELECTION]   = 32'h8000_0000;
        v[CFG_NOISE_GAIN]        = 32'hFFFF_FFFF;
        v[CFG_NONDECISION_TICKS] = 32'hFFFF_FFFF;
      end
      6: begin
        foreach (v[i]) v[i] = $urandom;
      end
      7: v[CFG_NONDECISION_TICKS] = 32'hFFFF_FFFF - $urandom_range(50);
      default: ;
    endcase
    foreach (v[i]) write_reg(cfg_idx_t'(i), v[i]);
  endtask

  always @(posedge clk) begin
    out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin : check_results
    decision_t want;
    if (rst_n && out_valid && !out_stall) begin
      decisions_seen++;
      if (pending_decisions.size() == 0) begin
        $error("unexpected item: choice %0b reaction_ticks %0d", out_choice,
               out_reaction_ticks);
        mismatches++;
      end else begin
        want = pending_decisions.pop_front();
        if (out_choice !== want.choice) begin
          $error("choice: expected %0b, got %0b", want.choice, out_choice);
          mismatches++;
        end
        if (out_reaction_ticks !== want.ticks) begin
          $error("reaction_ticks: expected %0d, got %0d", want.ticks, out_reaction_ticks);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= HANG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    stim_row_t script[$];
    script = '{
      // reset settings: zero gain and drift, nothing moves
      pair_row(16'h0000, 16'h0000, CHK_NONE, 1'b0, 32'd0),
      pair_row(16'h7FFF, 16'h8000, CHK_NONE, 1'b0, 32'd0),
      // zero response bound: level zero takes the lower side
      reg_row(CFG_RESPONSE_BOUND, 32'd0),
      pair_row(16'h0000, 16'h0000, CHK_HIT, 1'b0, 32'd3),
      // reaction time sum saturates
      reg_row(CFG_NONDECISION_TICKS, 32'hFFFF_FFFF),
      pair_row(16'h0000, 16'h0000, CHK_HIT, 1'b0, 32'hFFFF_FFFF),
      reg_row(CFG_NONDECISION_TICKS, 32'd5),
      reg_row(CFG_RESPONSE_BOUND, 32'h1_0000),
      reg_row(CFG_SELECTION_BOUND, 32'd0),
      reg_row(CFG_DRIFT_AFTER_UPPER, 32'h1_0000),
      reg_row(CFG_DRIFT_AFTER_LOWER, 32'hFFFF_0000),
      // zero selection bound: zero level enters the upper stage two
      pair_row(16'h0000, 16'h0000, CHK_NONE, 1'b0, 32'd0),
      pair_row(16'h0000, 16'h0000, CHK_HIT, 1'b1, 32'd7),
      reg_row(CFG_SELECTION_BOUND, 32'h8000),
      reg_row(CFG_DRIFT_SELECTION, 32'hFFFF_0000),
      pair_row(16'h0000, 16'h0000, CHK_NONE, 1'b0, 32'd0),
      pair_row(16'h0000, 16'h0000, CHK_HIT, 1'b0, 32'd7),
      // both levels cross on one tick: response decides
      reg_row(CFG_DRIFT_STAGE_ONE, 32'h2_0000),
      pair_row(16'h0000, 16'h0000, CHK_HIT, 1'b1, 32'd6),
      // full-scale settings, levels saturate
      reg_row(CFG_NOISE_GAIN, 32'hFFFF_FFFF),
      reg_row(CFG_RESPONSE_BOUND, 32'h7FFF_FFFF),
      reg_row(CFG_SELECTION_BOUND, 32'h7FFF_FFFF),
      reg_row(CFG_DRIFT_STAGE_ONE, 32'h7FFF_FFFF),
      reg_row(CFG_DRIFT_SELECTION, 32'h8000_0000),
      pair_row(16'h7FFF, 16'h8000, CHK_PRED, 1'b0, 32'd0),
      reg_row(CFG_DRIFT_STAGE_ONE, 32'h8000_0000),
      pair_row(16'h8000, 16'h7FFF, CHK_PRED, 1'b0, 32'd0),
      reg_row(CFG_DRIFT_STAGE_ONE, 32'd0),
      reg_row(CFG_RESPONSE_BOUND, 32'h1_0000),
      reg_row(CFG_SELECTION_BOUND, 32'h1_0000),
      reg_row(CFG_NOISE_GAIN, 32'h1_0000),
      pair_row(16'h1000, 16'h1000, CHK_PRED, 1'b0, 32'd0),
      pair_row(16'hFFFF, 16'h0001, CHK_PRED, 1'b0, 32'd0),
      pair_row(16'h0001, 16'hFFFF, CHK_PRED, 1'b0, 32'd0),
      // noise term of exactly one half LSB rounds away from zero
      reg_row(CFG_NOISE_GAIN, 32'h800),
      pair_row(16'hFFFF, 16'hFFFF, CHK_PRED, 1'b0, 32'd0),
      pair_row(16'h0001, 16'h0001, CHK_PRED, 1'b0, 32'd0)
    };
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    foreach (script[i]) begin
      if (script[i].kind == ROW_REG) write_reg(script[i].idx, script[i].data);
      else send_pair(script[i]);
    end
    for (int p = 0; p < PHASES; p++) begin
      configure_phase(p);
      case (p % 4)
        0: begin send_gap_pct = 0;  stall_pct = 0;  end
        1: begin send_gap_pct = 46; stall_pct = 0;  end
        2: begin send_gap_pct = 0;  stall_pct = 46; end
        default: begin send_gap_pct = 6; stall_pct = 6; end
      endcase
      repeat (PAIRS_PER_PHASE)
        send_pair(pair_row(draw_sample(), draw_sample(), CHK_PRED, 1'b0, 32'd0));
    end
    in_valid  <= 1'b0;
    cfg_valid <= 1'b0;
    while (pending_decisions.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    $display("Ran %0d noise pairs over %0d register writes in %0d phases; %0d decisions checked",
             pairs_sent, reg_writes, PHASES + 1, decisions_seen);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/dsdt_pkg.sv
hw/rtl/dsdt_noise.sv
hw/rtl/dual_stage_diffusion_trial.sv
hw/rtl/dsdt_port_check.sv
test/testbench.sv
